// ----- rtl/julian_gregorian_day_number_converter_unit_macros.svh -----
// assertion macros shared by the checker
`ifndef JULIAN_GREGORIAN_DAY_NUMBER_CONVERTER_UNIT_MACROS_SVH
`define JULIAN_GREGORIAN_DAY_NUMBER_CONVERTER_UNIT_MACROS_SVH

// implication checked on every edge outside reset
`define JGD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// implication whose consequent is checked in the next cycle
`define JGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ----- rtl/jgdc_pkg.sv -----
`default_nettype none
package jgdc_pkg;

   localparam int YearW = 14;
   localparam int DayNumW = 23;

   typedef enum logic [0:0] {
      OP_TO_DAY  = 1'b0,
      OP_TO_DATE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      SEL_JULIAN    = 2'd0,
      SEL_GREGORIAN = 2'd1,
      SEL_REFORM    = 2'd2,
      SEL_REFORM_B  = 2'd3
   } cal_select_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_MONTH = 2'd1,
      ERR_DAY   = 2'd2,
      ERR_RSVD  = 2'd3
   } error_type;

   // classified item from front to back
   typedef struct packed {
      logic                       to_date;
      logic [1:0]                 sel;
      logic signed [15:0]         year;
      logic [3:0]                 month;
      logic [4:0]                 day;
      logic signed [DayNumW-1:0]  day_number;
      logic [1:0]                 err;
   } item_type;

   // result item
   typedef struct packed {
      logic [DayNumW-1:0] day_count;
      logic [YearW-1:0]   year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [2:0]         weekday;
      logic               leap;
      logic               greg;
      logic [1:0]         err;
   } result_type;

   // cumulative days before month m (index 1..12)
   function automatic logic [8:0] cum_days(input logic [3:0] m, input logic leap);
      logic [8:0] v;
      unique case (m)
         4'd2:    v = 9'd31;
         4'd3:    v = 9'd59;
         4'd4:    v = 9'd90;
         4'd5:    v = 9'd120;
         4'd6:    v = 9'd151;
         4'd7:    v = 9'd181;
         4'd8:    v = 9'd212;
         4'd9:    v = 9'd243;
         4'd10:   v = 9'd273;
         4'd11:   v = 9'd304;
         4'd12:   v = 9'd334;
         default: v = 9'd0;
      endcase
      if (leap && m > 4'd2) begin
         v = v + 9'd1;
      end
      return v;
   endfunction

   // leap rule; y mod 100 and mod 400 given by caller
   function automatic logic leap_of(input logic greg, input logic [1:0] y4,
                                    input logic c100, input logic c400);
      logic r;
      if (!greg) begin
         r = (y4 == 2'd0);
      end else if (c400) begin
         r = 1'b1;
      end else if (c100) begin
         r = 1'b0;
      end else begin
         r = (y4 == 2'd0);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/jgdc_front.sv -----
`default_nettype none
// accepts transactions and checks the date fields
module jgdc_front (
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_opcode,
   input  wire logic [1:0]                 req_calendar_select,
   input  wire logic [13:0]                req_year,
   input  wire logic [3:0]                 req_month,
   input  wire logic [4:0]                 req_day,
   input  wire logic signed [22:0]         req_day_number,
   output logic                            push,
   output jgdc_pkg::item_type              push_item,
   input  wire logic                       queue_full
);
   import jgdc_pkg::*;

   logic bad_month;

   assign req_ready = !queue_full;
   assign push = req_valid && req_ready;

   // classify
   always_comb begin
      bad_month = (req_month == 4'd0) || (req_month > 4'd12);
      push_item.to_date = (req_opcode == OP_TO_DATE);
      push_item.sel = req_calendar_select;
      push_item.year = $signed({2'b00, req_year});
      push_item.month = req_month;
      push_item.day = req_day;
      push_item.day_number = req_day_number;
      if (req_opcode == OP_TO_DATE) begin
         push_item.err = ERR_NONE;
      end else if (bad_month) begin
         push_item.err = ERR_MONTH;
      end else if (req_day == 5'd0) begin
         push_item.err = ERR_DAY;
      end else begin
         push_item.err = ERR_NONE;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/jgdc_queue.sv -----
`default_nettype none
// two-entry queue between front and back
module jgdc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire jgdc_pkg::item_type  push_item,
   output logic                     full,
   output logic                     pop_valid,
   output jgdc_pkg::item_type       pop_item,
   input  wire logic                pop
);
   import jgdc_pkg::*;

   item_type  mem_ff [2];
   logic      wr_ptr_ff, wr_ptr_in;
   logic      rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/jgdc_back.sv -----
`default_nettype none
// conversion pipeline; stalls only when the output stage is held
module jgdc_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic signed [22:0]       reform_day,
   input  wire logic                     in_valid,
   input  wire jgdc_pkg::item_type       in_item,
   output logic                          in_pop,
   output logic                          out_valid,
   output jgdc_pkg::result_type          out_result,
   input  wire logic                     out_ready
);
   import jgdc_pkg::*;

   localparam int Stages = 6;
   // 2^32 times 400/146097 and 4/1461, the inverse mean year lengths
   localparam logic signed [24:0] GregYearRecip = 25'sd11759221;
   localparam logic signed [24:0] JulYearRecip = 25'sd11758980;
   // 30 times 400; keeps biased years positive over the range in use
   localparam logic signed [15:0] YearBias = 16'sd12000;
   // ceil(2^21 / 100), which is also ceil(2^23 / 400)
   localparam logic [14:0] CentRecip = 15'd20972;
   // multiple of 7 that keeps the weekday operand positive
   localparam logic signed [24:0] WeekBias = 25'sd7000000;
   // ceil(2^27 / 7)
   localparam logic [24:0] WeekRecip = 25'd19173962;

   // per-stage work record
   typedef struct packed {
      item_type             it;
      logic signed [15:0]   yp;        // year minus one, or estimate
      logic signed [24:0]   js, gs;    // year starts julian and gregorian
      logic signed [24:0]   js1;       // next year start
      logic signed [24:0]   dayn;
      logic                 greg;
      logic                 leap;
      logic signed [24:0]   doy;
      logic [3:0]           mo;
      logic [2:0]           wd;
   } work_type;

   logic [Stages-1:0] v_ff;
   work_type w_ff [Stages];
   work_type w_in [Stages];
   logic adv;
   result_type res_ff, res_in;
   logic res_v_ff;

   assign adv = !res_v_ff || out_ready;
   assign in_pop = in_valid && adv;
   assign out_valid = res_v_ff;
   assign out_result = res_ff;

   // floor divide of a year by 4
   function automatic logic signed [15:0] fdiv4(input logic signed [15:0] a);
      return a >>> 2;
   endfunction

   // biased year times the reciprocal of 100; bits 21 up give /100, bits 23 up /400
   function automatic logic [30:0] cent_prod(input logic signed [15:0] a);
      logic [15:0] u;
      u = 16'(a + YearBias);
      return 31'(u) * 31'(CentRecip);
   endfunction

   function automatic logic signed [15:0] fdiv100(input logic signed [15:0] a);
      logic [30:0] p;
      p = cent_prod(a);
      return $signed(16'(p[30:21])) - 16'sd120;
   endfunction

   function automatic logic signed [15:0] fdiv400(input logic signed [15:0] a);
      logic [30:0] p;
      p = cent_prod(a);
      return $signed(16'(p[30:23])) - 16'sd30;
   endfunction

   function automatic logic signed [24:0] ystart(input logic greg,
                                                 input logic signed [15:0] p);
      logic signed [24:0] s;
      s = 25'(p) * 25'sd365 + 25'(fdiv4(p));
      if (greg) begin
         s = s - 25'(fdiv100(p)) + 25'(fdiv400(p)) - 25'sd72742;
      end else begin
         s = s - 25'sd72744;
      end
      return s;
   endfunction

   function automatic logic lp(input logic greg, input logic signed [15:0] y);
      return leap_of(greg, y[1:0], fdiv100(y) * 16'sd100 == y,
                     fdiv400(y) * 16'sd400 == y);
   endfunction

   // stage 0: year estimate for day numbers, year-1 for dates
   always_comb begin
      logic signed [23:0] m;
      logic signed [24:0] rcp;
      logic signed [48:0] prod;
      logic g0;
      w_in[0] = '0;
      w_in[0].it = in_item;
      w_in[0].dayn = 25'(in_item.day_number);
      g0 = (in_item.day_number >= reform_day);
      w_in[0].greg = g0;
      // estimate lands within one year of the true one; stage 2 corrects it
      if (g0) begin
         m = 24'(in_item.day_number) + 24'sd72743;
         rcp = GregYearRecip;
      end else begin
         m = 24'(in_item.day_number) + 24'sd72745;
         rcp = JulYearRecip;
      end
      prod = 49'(m) * 49'(rcp);
      if (in_item.to_date) begin
         w_in[0].yp = $signed(prod[47:32]) + 16'sd1;
      end else begin
         w_in[0].yp = in_item.year - 16'sd1;
      end
   end

   // stage 1: year starts
   always_comb begin
      w_in[1] = w_ff[0];
      if (w_ff[0].it.to_date) begin
         w_in[1].js = ystart(w_ff[0].greg, w_ff[0].yp - 16'sd1);
         w_in[1].js1 = ystart(w_ff[0].greg, w_ff[0].yp);
      end else begin
         w_in[1].js = ystart(1'b0, w_ff[0].yp);
         w_in[1].gs = ystart(1'b1, w_ff[0].yp);
      end
   end

   // stage 2: correct estimate or compute both day counts
   always_comb begin
      logic signed [15:0] y;
      w_in[2] = w_ff[1];
      y = w_ff[1].yp;
      if (w_ff[1].it.to_date) begin
         if (w_ff[1].dayn < w_ff[1].js) begin
            w_in[2].yp = y - 16'sd1;
         end else if (w_ff[1].dayn >= w_ff[1].js1) begin
            w_in[2].yp = y + 16'sd1;
         end
      end else begin
         w_in[2].js = w_ff[1].js + 25'(cum_days(w_ff[1].it.month, lp(1'b0, y + 16'sd1)))
                      + 25'(w_ff[1].it.day) - 25'sd1;
         w_in[2].gs = w_ff[1].gs + 25'(cum_days(w_ff[1].it.month, lp(1'b1, y + 16'sd1)))
                      + 25'(w_ff[1].it.day) - 25'sd1;
      end
   end

   // stage 3: pick calendar, year start of final year
   always_comb begin
      logic g;
      w_in[3] = w_ff[2];
      if (w_ff[2].it.to_date) begin
         w_in[3].js = ystart(w_ff[2].greg, w_ff[2].yp - 16'sd1);
         w_in[3].leap = lp(w_ff[2].greg, w_ff[2].yp);
      end else begin
         unique case (w_ff[2].it.sel)
            SEL_JULIAN:    g = 1'b0;
            SEL_GREGORIAN: g = 1'b1;
            default:       g = (w_ff[2].gs >= 25'(reform_day));
         endcase
         w_in[3].greg = g;
         w_in[3].dayn = g ? w_ff[2].gs : w_ff[2].js;
         w_in[3].yp = w_ff[2].yp + 16'sd1;
         w_in[3].leap = lp(g, w_ff[2].yp + 16'sd1);
      end
   end

   // stage 4: day of year, month search and weekday
   always_comb begin
      logic signed [24:0] d;
      logic [23:0] wu;
      logic [48:0] wq;
      w_in[4] = w_ff[3];
      d = w_ff[3].dayn - w_ff[3].js;
      w_in[4].doy = d;
      w_in[4].mo = 4'd1;
      for (int i = 2; i <= 12; i++) begin
         if (25'(cum_days(4'(i), w_ff[3].leap)) <= d) begin
            w_in[4].mo = 4'(i);
         end
      end
      // (n - 1) mod 7 through a reciprocal multiply
      wu = 24'(w_ff[3].dayn - 25'sd1 + WeekBias);
      wq = 49'(wu) * 49'(WeekRecip);
      w_in[4].wd = 3'(wu - 24'(wq[48:27]) * 24'd7);
   end

   // stage 5: day of month
   always_comb begin
      w_in[5] = w_ff[4];
      w_in[5].doy = w_ff[4].doy - 25'(cum_days(w_ff[4].mo, w_ff[4].leap)) + 25'sd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[Stages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff[0] <= w_in[0];
         for (int s = 1; s < Stages; s++) begin
            w_ff[s] <= w_in[s];
         end
      end
   end

   // result formatting
   always_comb begin
      work_type w;
      w = w_ff[Stages-1];
      res_in = '0;
      if (w.it.err != ERR_NONE) begin
         res_in.err = w.it.err;
      end else begin
         res_in.day_count = w.dayn[22:0];
         res_in.year = w.yp[13:0];
         if (w.it.to_date) begin
            res_in.month = w.mo;
            res_in.day = w.doy[4:0];
         end else begin
            res_in.month = w.it.month;
            res_in.day = w.it.day;
         end
         res_in.weekday = w.wd;
         res_in.leap = w.leap;
         res_in.greg = w.greg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
      end else if (adv) begin
         res_v_ff <= v_ff[Stages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/julian_gregorian_day_number_converter_unit.sv -----
// channel | direction | handshake
// req_    | in        | req_valid / req_ready
// rsp_    | out       | rsp_valid / rsp_ready
// csr_    | in        | csr_write_enable, no wait
// one transaction per cycle sustained while rsp_ready is held high; from accept to rsp_valid
// an item passes the queue, six pipeline stages in the back end and the output register
// reset is synchronous; queue, pipeline and output valid clear, reform_day loads 504993
// a held rsp_ stalls the whole back end; the two-entry queue then fills and drops req_ready
`default_nettype none
module julian_gregorian_day_number_converter_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic signed [22:0] csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_opcode,
   input  wire logic [1:0]         req_calendar_select,
   input  wire logic [13:0]        req_year,
   input  wire logic [3:0]         req_month,
   input  wire logic [4:0]         req_day,
   input  wire logic signed [22:0] req_day_number,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [22:0]      rsp_day_count,
   output logic [13:0]             rsp_year_out,
   output logic [3:0]              rsp_month_out,
   output logic [4:0]              rsp_day_out,
   output logic [2:0]              rsp_weekday,
   output logic                    rsp_leap_year,
   output logic                    rsp_calendar_used,
   output logic [1:0]              rsp_error_code
);
   import jgdc_pkg::*;

   logic signed [22:0] reform_ff;
   logic push, full, pop, pop_valid;
   item_type push_item, pop_item;
   result_type res;

   // reform threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         reform_ff <= 23'sd504993;
      end else if (csr_write_enable) begin
         reform_ff <= csr_write_data;
      end
   end

   jgdc_front u_front (
      .req_valid, .req_ready, .req_opcode, .req_calendar_select,
      .req_year, .req_month, .req_day, .req_day_number,
      .push, .push_item, .queue_full(full)
   );

   jgdc_queue u_queue (
      .clock, .reset, .push, .push_item, .full,
      .pop_valid, .pop_item, .pop
   );

   jgdc_back u_back (
      .clock, .reset, .reform_day(reform_ff), .in_valid(pop_valid), .in_item(pop_item),
      .in_pop(pop), .out_valid(rsp_valid), .out_result(res), .out_ready(rsp_ready)
   );

   assign rsp_day_count = res.day_count;
   assign rsp_year_out = res.year;
   assign rsp_month_out = res.month;
   assign rsp_day_out = res.day;
   assign rsp_weekday = res.weekday;
   assign rsp_leap_year = res.leap;
   assign rsp_calendar_used = res.greg;
   assign rsp_error_code = res.err;
endmodule
`default_nettype wire

// ----- rtl/jgdc_checker.sv -----
`default_nettype none
`include "julian_gregorian_day_number_converter_unit_macros.svh"
// port-level checks
module jgdc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_error_code,
   input wire logic [3:0] rsp_month_out,
   input wire logic [2:0] rsp_weekday
);
   `JGD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `JGD_ASSERT_IMPL(a_err_range, clock, reset, rsp_valid, rsp_error_code != 2'd3)
   `JGD_ASSERT_IMPL(a_weekday, clock, reset, rsp_valid, rsp_weekday != 3'd7)
   `JGD_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && rsp_error_code != 2'd0,
                    rsp_month_out == 4'd0)
endmodule

bind julian_gregorian_day_number_converter_unit jgdc_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_error_code, .rsp_month_out, .rsp_weekday
);
`default_nettype wire

// ----- verif/julian_gregorian_day_number_converter_unit_test.sv -----
`default_nettype none
module julian_gregorian_day_number_converter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import jgdc_pkg::*;

   localparam longint JulEpoch  = 72744;
   localparam longint GregEpoch = 72742;
   localparam int     Latency   = 7;
   localparam longint CycleLimit = 400000;

   typedef struct {
      opcode_type     op;
      cal_select_type sel;
      logic [13:0]    year;
      logic [3:0]     month;
      logic [4:0]     day;
      logic [22:0]    day_number;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic signed [22:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = 1'b0;
   logic [1:0] req_calendar_select = '0;
   logic [13:0] req_year = '0;
   logic [3:0] req_month = '0;
   logic [4:0] req_day = '0;
   logic signed [22:0] req_day_number = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [22:0] rsp_day_count;
   logic [13:0] rsp_year_out;
   logic [3:0] rsp_month_out;
   logic [4:0] rsp_day_out;
   logic [2:0] rsp_weekday;
   logic rsp_leap_year;
   logic rsp_calendar_used;
   logic [1:0] rsp_error_code;
   logic req_ready_seen = 1'b0;

   julian_gregorian_day_number_converter_unit uut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_calendar_select(req_calendar_select), .req_year(req_year),
      .req_month(req_month), .req_day(req_day), .req_day_number(req_day_number),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_day_count(rsp_day_count),
      .rsp_year_out(rsp_year_out), .rsp_month_out(rsp_month_out),
      .rsp_day_out(rsp_day_out), .rsp_weekday(rsp_weekday),
      .rsp_leap_year(rsp_leap_year), .rsp_calendar_used(rsp_calendar_used),
      .rsp_error_code(rsp_error_code)
   );

   request_type pending_requests[$];
   result_type  expected_dates[$];
   longint      reform_threshold;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          error_count = 0;
   int          checked_count = 0;
   int          accepted_count = 0;
   longint      cycle_count = 0;

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // floored division and positive modulus
   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if (a % b < 0) q--;
      return q;
   endfunction

   function automatic longint pos_mod(longint a, longint b);
      longint r;
      r = a % b;
      if (r < 0) r += b;
      return r;
   endfunction

   function automatic bit leap_in(bit greg, longint y);
      if (!greg) return pos_mod(y, 4) == 0;
      if (pos_mod(y, 400) == 0) return 1'b1;
      if (pos_mod(y, 100) == 0) return 1'b0;
      return pos_mod(y, 4) == 0;
   endfunction

   function automatic longint days_before_month(int m, bit leap);
      int base[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      return base[m] + ((leap && m > 2) ? 1 : 0);
   endfunction

   // day number of 1 january
   function automatic longint new_year_day(bit greg, longint y);
      longint p;
      p = y - 1;
      if (!greg) return p * 365 + floor_div(p, 4) - JulEpoch;
      return p * 365 + floor_div(p, 4) - floor_div(p, 100) + floor_div(p, 400) - GregEpoch;
   endfunction

   function automatic longint day_of_date(bit greg, longint y, int m, int d);
      return new_year_day(greg, y) + days_before_month(m, leap_in(greg, y)) + d - 1;
   endfunction

   function automatic result_type fill_result(longint dc, longint y, int m, int d, bit greg);
      result_type r;
      r.day_count = dc[22:0];
      r.year = y[13:0];
      r.month = m[3:0];
      r.day = d[4:0];
      r.weekday = 3'(pos_mod(dc - 1, 7));
      r.leap = leap_in(greg, y);
      r.greg = greg;
      r.err = ERR_NONE;
      return r;
   endfunction

   // expected conversion result
   function automatic result_type convert_date(request_type rq);
      result_type r;
      longint y, n, est, doy;
      bit greg;
      int mo;
      r = '0;
      y = rq.year;
      n = $signed(rq.day_number);
      if (rq.op == OP_TO_DAY) begin
         if (rq.month < 1 || rq.month > 12) begin
            r.err = ERR_MONTH;
            return r;
         end
         if (rq.day == 0) begin
            r.err = ERR_DAY;
            return r;
         end
         if (rq.sel == SEL_JULIAN) greg = 1'b0;
         else if (rq.sel == SEL_GREGORIAN) greg = 1'b1;
         else greg = day_of_date(1'b1, y, rq.month, rq.day) >= reform_threshold;
         return fill_result(day_of_date(greg, y, rq.month, rq.day), y,
                            rq.month, rq.day, greg);
      end
      greg = n >= reform_threshold;
      if (greg) est = floor_div((n + 72743) * 10000, 3652425) + 1;
      else est = floor_div((n + 72745) * 4, 1461) + 1;
      if (n < new_year_day(greg, est)) est--;
      else if (n >= new_year_day(greg, est + 1)) est++;
      doy = n - new_year_day(greg, est);
      mo = 1;
      for (int i = 2; i <= 12; i++)
         if (days_before_month(i, leap_in(greg, est)) <= doy) mo = i;
      return fill_result(n, est, mo, int'(doy - days_before_month(mo, leap_in(greg, est)) + 1),
                         greg);
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready_seen) begin
            accepted_count++;
         end
         if ((!req_valid || req_ready_seen) && pending_requests.size() > 0
             && $urandom_range(99) >= send_idle_pct) begin
            request_type rq;
            rq = pending_requests.pop_front();
            expected_dates.push_back(convert_date(rq));
            req_valid <= 1'b1;
            req_opcode <= rq.op;
            req_calendar_select <= rq.sel;
            req_year <= rq.year;
            req_month <= rq.month;
            req_day <= rq.day;
            req_day_number <= rq.day_number;
         end else if (req_valid && req_ready_seen) begin
            req_valid <= 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // transaction acceptance seen at the rising edge
   always @(posedge clock) begin
      req_ready_seen <= req_valid && req_ready && !reset;
   end

   // monitor
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time,
                     {rsp_day_count, rsp_year_out, rsp_month_out, rsp_day_out});
            error_count++;
         end else begin
            result_type e;
            result_type a;
            e = expected_dates.pop_front();
            a = '{rsp_day_count, rsp_year_out, rsp_month_out, rsp_day_out, rsp_weekday,
                  rsp_leap_year, rsp_calendar_used, rsp_error_code};
            checked_count++;
            if (a.day_count != e.day_count)
               $display("%0t: day_count expected %0d actual %0d", $time,
                        $signed(e.day_count), $signed(a.day_count));
            if (a.year != e.year)
               $display("%0t: year expected %0d actual %0d", $time, e.year, a.year);
            if (a.month != e.month)
               $display("%0t: month expected %0d actual %0d", $time, e.month, a.month);
            if (a.day != e.day)
               $display("%0t: day expected %0d actual %0d", $time, e.day, a.day);
            if (a.weekday != e.weekday)
               $display("%0t: weekday expected %0d actual %0d", $time, e.weekday, a.weekday);
            if (a.leap != e.leap)
               $display("%0t: leap expected %0d actual %0d", $time, e.leap, a.leap);
            if (a.greg != e.greg)
               $display("%0t: calendar expected %0d actual %0d", $time, e.greg, a.greg);
            if (a.err != e.err)
               $display("%0t: error expected %0d actual %0d", $time, e.err, a.err);
            if (a != e) error_count++;
         end
      end
      if (cycle_count > CycleLimit) begin
         $display("julian_gregorian_day_number_converter_unit_test: FAIL");
         $finish;
      end
   end

   function automatic request_type date_request(cal_select_type sel, int y, int m, int d);
      request_type rq;
      rq.op = OP_TO_DAY;
      rq.sel = sel;
      rq.year = y[13:0];
      rq.month = m[3:0];
      rq.day = d[4:0];
      rq.day_number = 23'($urandom);
      return rq;
   endfunction

   function automatic request_type number_request(longint n);
      request_type rq;
      rq.op = OP_TO_DATE;
      rq.sel = cal_select_type'($urandom_range(3));
      rq.year = 14'($urandom);
      rq.month = 4'($urandom);
      rq.day = 5'($urandom);
      rq.day_number = n[22:0];
      return rq;
   endfunction

   function automatic request_type random_request();
      int k;
      k = $urandom_range(99);
      if (k < 40)
         return date_request(cal_select_type'($urandom_range(3)), $urandom_range(9999, 1),
                             $urandom_range(12, 1), $urandom_range(31, 1));
      if (k < 48)
         return date_request(cal_select_type'($urandom_range(3)), $urandom_range(16383),
                             $urandom_range(15), $urandom_range(31));
      if (k < 90)
         return number_request($urandom_range(3579389 + 72744) - 72744);
      if (k < 95)
         return number_request(reform_threshold + $urandom_range(800) - 400);
      return number_request($signed(23'($urandom)));
   endfunction

   // wait for the block to drain, then write the threshold
   task automatic drain_and_write(longint value);
      while (pending_requests.size() > 0 || expected_dates.size() > 0 || req_valid)
         @(posedge clock);
      repeat (Latency + 2) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value[22:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      reform_threshold = value;
   endtask

   task automatic random_phase(int count, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      repeat (count) pending_requests.push_back(random_request());
      while (pending_requests.size() > 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      longint settings[5] = '{504993, -72744, 3579390, 0, 577737};
      reform_threshold = 504993;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, error cases, overflow into next month
      pending_requests.push_back(date_request(SEL_JULIAN, 1, 1, 1));
      pending_requests.push_back(date_request(SEL_GREGORIAN, 9999, 12, 31));
      pending_requests.push_back(date_request(SEL_REFORM, 1582, 10, 15));
      pending_requests.push_back(date_request(SEL_REFORM_B, 1582, 10, 4));
      pending_requests.push_back(date_request(SEL_JULIAN, 200, 3, 1));
      pending_requests.push_back(date_request(SEL_GREGORIAN, 1900, 2, 30));
      pending_requests.push_back(date_request(SEL_GREGORIAN, 2000, 2, 29));
      pending_requests.push_back(date_request(SEL_JULIAN, 2024, 0, 5));
      pending_requests.push_back(date_request(SEL_JULIAN, 2024, 13, 5));
      pending_requests.push_back(date_request(SEL_JULIAN, 2024, 15, 0));
      pending_requests.push_back(date_request(SEL_GREGORIAN, 2024, 6, 0));
      pending_requests.push_back(date_request(SEL_GREGORIAN, 0, 1, 1));
      pending_requests.push_back(date_request(SEL_JULIAN, 16383, 12, 31));
      pending_requests.push_back(number_request(0));
      pending_requests.push_back(number_request(-72744));
      pending_requests.push_back(number_request(3579389));
      pending_requests.push_back(number_request(504992));
      pending_requests.push_back(number_request(504993));
      pending_requests.push_back(number_request(-4194304));
      pending_requests.push_back(number_request(4194303));
      pending_requests.push_back(number_request(-1));
      while (pending_requests.size() > 0) @(posedge clock);

      // pause until every expected result has come
      while (expected_dates.size() > 0) @(posedge clock);

      for (int s = 0; s < 5; s++) begin
         drain_and_write(settings[s]);
         random_phase(30, 0, 0);
         random_phase(30, 60, 0);
         random_phase(30, 0, 60);
         random_phase(30, 12, 12);
      end

      while (expected_dates.size() > 0 || req_valid) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
      $display("covered both conversions, all calendar selects, errors and 5 thresholds");
      $display("%0d transactions accepted, %0d results checked", accepted_count,
               checked_count);
      if (error_count == 0 && expected_dates.size() == 0) begin
         $display("julian_gregorian_day_number_converter_unit_test: PASS");
      end else begin
         $display("julian_gregorian_day_number_converter_unit_test: FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
